// ===== design/lwd_pkg.sv =====
package lwd_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic CMD_ARRIVAL  = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_REFUSED    = 2'd1;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd2;
  localparam logic [1:0] ST_IDLE_DONE  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SERVERS_IN_USE = 1'b0;
  localparam logic CFG_SERVED_LIMIT   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] time_now;
    logic [3:0]  job_length;
    logic [2:0]  server_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  server;
    logic        started;
    logic [31:0] finish_time;
    logic [15:0] served_total;
    logic [15:0] server_started_count;
    logic [15:0] server_busy_time;
    logic [1:0]  status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic arrive;
    logic cread;
    logic cpop;
    logic load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic arrival;
    logic refuse;
    logic oor;
    logic scan_last;
    logic sel_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== design/lwd_datapath.sv =====
module lwd_datapath import lwd_pkg::*; #(
  parameter int SERVERS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  ctl_t        ctl,
  output sts_t        sts
);

  localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = $clog2(QUEUE_DEPTH * 15 + 1);
  localparam int AW = $clog2(SERVERS * QUEUE_DEPTH);
  localparam int MD = SERVERS * QUEUE_DEPTH;

  // Configuration and global counters.
  logic [3:0]  servers_in_use;
  logic [15:0] served_limit;
  logic [15:0] completions;

  // Per-server state.
  logic          busy    [SERVERS];
  logic [31:0]   free_at [SERVERS];
  logic [15:0]   started [SERVERS];
  logic [15:0]   btime   [SERVERS];
  logic [QW-1:0] head    [SERVERS];
  logic [CW-1:0] count   [SERVERS];
  logic [WW-1:0] wsum    [SERVERS];

  // Job queues of all servers share one memory.
  logic [3:0] qmem [MD];
  logic [3:0] q_rd;

  // Working registers of the transaction in progress.
  in_item_t  item;
  logic [SW-1:0] sel;
  logic [SW-1:0] best;
  logic [33:0]   best_load;
  out_item_t res;
  out_item_t res_init;

  logic [SW-1:0] n_last;
  logic [31:0]   remaining;
  logic [33:0]   load;
  logic          take;
  logic [SW-1:0] best_next;
  logic [3:0]    begin_len;
  logic [32:0]   fin_sum;
  logic [31:0]   fin;
  logic [15:0]   sc_inc;
  logic [16:0]   bt_sum;
  logic [15:0]   bt_inc;
  logic [QW:0]   tail_w;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_next;
  logic [AW-1:0] qaddr_w;
  logic [AW-1:0] qaddr_r;
  logic          can_start;
  logic          full;
  logic          has_queued;
  logic [15:0]   comp_inc;

  // Last server index considered, with out-of-range counts clamped.
  always_comb begin
    if (servers_in_use == 4'd0) begin
      n_last = '0;
    end else if ({1'b0, servers_in_use} >= 5'(SERVERS)) begin
      n_last = SW'(SERVERS - 1);
    end else begin
      n_last = SW'(servers_in_use - 4'd1);
    end
  end

  // Outstanding work of the scanned server in 24.8 time units.
  assign remaining = (busy[sel] && (free_at[sel] > item.time_now))
                     ? (free_at[sel] - item.time_now) : 32'd0;
  assign load      = 34'({wsum[sel], 8'h00}) + 34'(remaining);
  assign take      = (sel == '0) || (load < best_load);
  assign best_next = take ? sel : best;

  // Start of a job on the selected server.
  assign begin_len = ctl.cpop ? q_rd : item.job_length;
  assign fin_sum   = 33'(item.time_now) + 33'({begin_len, 8'h00});
  assign fin       = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
  assign sc_inc    = (started[sel] == 16'hFFFF) ? 16'hFFFF : started[sel] + 16'd1;
  assign bt_sum    = 17'(btime[sel]) + 17'(begin_len);
  assign bt_inc    = bt_sum[16] ? 16'hFFFF : bt_sum[15:0];
  assign comp_inc  = (completions == 16'hFFFF) ? 16'hFFFF : completions + 16'd1;

  // Queue pointers of the selected server.
  assign tail_w    = (QW+1)'(head[sel]) + (QW+1)'(count[sel]);
  assign tail      = (tail_w >= (QW+1)'(QUEUE_DEPTH))
                     ? QW'(tail_w - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_w);
  assign head_next = (head[sel] == QW'(QUEUE_DEPTH - 1)) ? '0 : head[sel] + QW'(1);
  assign qaddr_w   = AW'(AW'(sel) * AW'(QUEUE_DEPTH)) + AW'(tail);
  assign qaddr_r   = AW'(AW'(sel) * AW'(QUEUE_DEPTH)) + AW'(head[sel]);

  assign can_start  = !busy[sel] && (count[sel] == '0);
  assign full       = count[sel] >= CW'(QUEUE_DEPTH);
  assign has_queued = count[sel] != '0;

  // Status toward the controller.
  always_comb begin
    sts.arrival   = in_data.cmd == CMD_ARRIVAL;
    sts.refuse    = completions >= served_limit;
    sts.oor       = {2'b00, in_data.server_index} >= 5'(SERVERS);
    sts.scan_last = sel == n_last;
    sts.sel_busy  = busy[sel];
    sts.out_free  = !out_valid || !out_stall;
  end

  // Initial result of a newly accepted transaction.
  always_comb begin
    res_init = '0;
    if (in_data.cmd == CMD_ARRIVAL) begin
      res_init.status = sts.refuse ? ST_REFUSED : ST_OK;
    end else begin
      res_init.server = in_data.server_index;
      res_init.status = sts.oor ? ST_IDLE_DONE : ST_OK;
    end
  end

  // Queue memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.arrive && !can_start && !full) begin
      qmem[qaddr_w] <= item.job_length;
    end
    if (ctl.cread) begin
      q_rd <= qmem[qaddr_r];
    end
  end

  // Configuration, per-server state and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= 4'd3;
      served_limit   <= 16'd10;
      completions    <= '0;
      out_valid      <= 1'b0;
      for (int s = 0; s < SERVERS; s++) begin
        busy[s]    <= 1'b0;
        free_at[s] <= '0;
        started[s] <= '0;
        btime[s]   <= '0;
        head[s]    <= '0;
        count[s]   <= '0;
        wsum[s]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SERVERS_IN_USE: servers_in_use <= cfg_data[3:0];
          CFG_SERVED_LIMIT:   served_limit   <= cfg_data;
          default:            served_limit   <= served_limit;
        endcase
      end

      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Arrival on the chosen server: start at once, enqueue, or drop the job when the queue is full.
      if (ctl.arrive) begin
        if (can_start) begin
          busy[sel]    <= 1'b1;
          free_at[sel] <= fin;
          started[sel] <= sc_inc;
          btime[sel]   <= bt_inc;
        end else if (!full) begin
          count[sel] <= count[sel] + CW'(1);
          wsum[sel]  <= wsum[sel] + WW'(item.job_length);
        end
      end

      // Completion: free the server and start the head of its queue.
      if (ctl.cpop) begin
        completions <= comp_inc;
        busy[sel]   <= has_queued;
        if (has_queued) begin
          free_at[sel] <= fin;
          started[sel] <= sc_inc;
          btime[sel]   <= bt_inc;
          head[sel]    <= head_next;
          count[sel]   <= count[sel] - CW'(1);
          wsum[sel]    <= (wsum[sel] >= WW'(q_rd)) ? wsum[sel] - WW'(q_rd) : '0;
        end
      end
    end
  end

  // Transaction registers and the result under construction.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item <= in_data;
      sel  <= (in_data.cmd == CMD_ARRIVAL) ? '0 : SW'(in_data.server_index);
      res  <= res_init;
    end

    if (ctl.scan) begin
      best      <= best_next;
      best_load <= take ? load : best_load;
      sel       <= sts.scan_last ? best_next : sel + SW'(1);
    end

    if (ctl.arrive) begin
      res.server               <= 3'(sel);
      res.started              <= can_start;
      res.finish_time          <= can_start ? fin : 32'd0;
      res.server_started_count <= can_start ? sc_inc : started[sel];
      res.server_busy_time     <= can_start ? bt_inc : btime[sel];
      res.status               <= (!can_start && full) ? ST_QUEUE_FULL : ST_OK;
    end

    if (ctl.cread && !busy[sel]) begin
      res.server               <= item.server_index;
      res.server_started_count <= started[sel];
      res.server_busy_time     <= btime[sel];
      res.status               <= ST_IDLE_DONE;
    end

    if (ctl.cpop) begin
      res.server               <= item.server_index;
      res.started              <= has_queued;
      res.finish_time          <= has_queued ? fin : 32'd0;
      res.server_started_count <= has_queued ? sc_inc : started[sel];
      res.server_busy_time     <= has_queued ? bt_inc : btime[sel];
      res.status               <= ST_OK;
    end

    if (ctl.load) begin
      out_data <= {res.server, res.started, res.finish_time, completions,
                   res.server_started_count, res.server_busy_time, res.status};
    end
  end

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

  // A completion is only retired on a busy server.
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.cpop |-> busy[sel])
    else $error("completion retired on an idle server");

  // The scan never walks past the last active server.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ctl.scan |-> (sel <= n_last))
    else $error("server scan out of range");

endmodule

// ===== design/lwd_ctrl.sv =====
module lwd_ctrl import lwd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ARRIVE = 3'd2;
  localparam logic [2:0] S_CREAD  = 3'd3;
  localparam logic [2:0] S_CPOP   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = state != S_IDLE;

  // Next state and commands for the datapath.
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (sts.arrival) begin
            state_next = sts.refuse ? S_DONE : S_SCAN;
          end else begin
            state_next = sts.oor ? S_DONE : S_CREAD;
          end
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        ctl.arrive = 1'b1;
        state_next = S_DONE;
      end
      S_CREAD: begin
        ctl.cread  = 1'b1;
        state_next = sts.sel_busy ? S_CPOP : S_DONE;
      end
      S_CPOP: begin
        ctl.cpop   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/least_work_dispatcher.sv =====
// Arrival: scans the active servers, one compared per cycle (SCAN), then updates
// the chosen server (ARRIVE); completion: reads the queue memory (CREAD), and on a
// busy server retires the job (CPOP); a refused arrival or an unknown server skips
// to the result load (DONE). One transaction at a time; the next is accepted after
// the result enters the output register, which waits while the output is stalled.
// Reset (rst, synchronous): all server state and counters cleared, 3 servers, limit 10.
module least_work_dispatcher import lwd_pkg::*; #(
  parameter int SERVERS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  ctl_t ctl;
  sts_t sts;

  // Sequencer for one transaction at a time.
  lwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Server state, queues and result register.
  lwd_datapath #(
    .SERVERS     (SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ===== tb/sv/tb_least_work_dispatcher.sv =====
module tb_least_work_dispatcher;
  import lwd_pkg::*;

  localparam int NUM_SERVERS = 8;
  localparam int QDEPTH      = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SERVERS_IN_USE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  least_work_dispatcher #(.SERVERS(NUM_SERVERS), .QUEUE_DEPTH(QDEPTH)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the dispatcher state.
  logic [3:0]  job_fifo [NUM_SERVERS][QDEPTH];
  int          fifo_head [NUM_SERVERS];
  int          fifo_fill [NUM_SERVERS];
  int          fifo_work [NUM_SERVERS];
  bit          srv_busy [NUM_SERVERS];
  logic [31:0] srv_free_at [NUM_SERVERS];
  int          srv_jobs [NUM_SERVERS];
  int          srv_work [NUM_SERVERS];
  int          done_total;
  logic [3:0]  active_servers;
  logic [15:0] done_limit;

  out_item_t   pending_results[$];
  int          mismatches;
  int          out_hold;
  int          out_burst;
  int          in_burst;
  logic [31:0] clock_now;

  function automatic int sat16(int v);
    return (v > 16'hFFFF) ? 16'hFFFF : v;
  endfunction

  function automatic logic [31:0] start_job(int s, logic [31:0] now, logic [3:0] len);
    logic [32:0] fin;
    fin = {1'b0, now} + ({29'd0, len} << 8);
    if (fin[32]) fin = 33'h0FFFFFFFF;
    srv_busy[s]    = 1'b1;
    srv_free_at[s] = fin[31:0];
    srv_jobs[s]    = sat16(srv_jobs[s] + 1);
    srv_work[s]    = sat16(srv_work[s] + len);
    return fin[31:0];
  endfunction

  // Works out the result of one transaction and advances the shadow state.
  function automatic out_item_t dispatch_result(in_item_t it);
    out_item_t   r;
    int          n, best, s;
    longint      load, best_load;
    int          tail, qlen;
    r = '0;
    if (it.cmd == CMD_ARRIVAL) begin
      if (done_total >= done_limit) begin
        r.status = ST_REFUSED;
      end else begin
        n = active_servers;
        if (n < 1) n = 1;
        if (n > NUM_SERVERS) n = NUM_SERVERS;
        best = 0;
        best_load = 0;
        for (s = 0; s < n; s++) begin
          load = longint'(fifo_work[s]) << 8;
          if (srv_busy[s] && srv_free_at[s] > it.time_now)
            load += longint'(srv_free_at[s] - it.time_now);
          if (s == 0 || load < best_load) begin
            best_load = load;
            best = s;
          end
        end
        r.server = 3'(best);
        if (!srv_busy[best] && fifo_fill[best] == 0) begin
          r.finish_time = start_job(best, it.time_now, it.job_length);
          r.started = 1'b1;
        end else if (fifo_fill[best] >= QDEPTH) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          tail = (fifo_head[best] + fifo_fill[best]) % QDEPTH;
          job_fifo[best][tail] = it.job_length;
          fifo_fill[best]++;
          fifo_work[best] += it.job_length;
        end
        r.server_started_count = 16'(srv_jobs[best]);
        r.server_busy_time = 16'(srv_work[best]);
      end
    end else begin
      s = it.server_index;
      r.server = it.server_index;
      if (s >= NUM_SERVERS) begin
        r.status = ST_IDLE_DONE;
      end else begin
        if (!srv_busy[s]) begin
          r.status = ST_IDLE_DONE;
        end else begin
          srv_busy[s] = 1'b0;
          done_total = sat16(done_total + 1);
          if (fifo_fill[s] > 0) begin
            qlen = job_fifo[s][fifo_head[s]];
            fifo_head[s] = (fifo_head[s] + 1) % QDEPTH;
            fifo_fill[s]--;
            fifo_work[s] = (fifo_work[s] >= qlen) ? fifo_work[s] - qlen : 0;
            r.finish_time = start_job(s, it.time_now, qlen[3:0]);
            r.started = 1'b1;
          end
        end
        r.server_started_count = 16'(srv_jobs[s]);
        r.server_busy_time = 16'(srv_work[s]);
      end
    end
    r.served_total = 16'(done_total);
    return r;
  endfunction

  // Draws the wait before a transaction, with runs of back-to-back traffic.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  // Sends one transaction; the expected result is the typed one when given.
  task automatic send_item(in_item_t it, bit use_typed, out_item_t typed);
    int        gap;
    out_item_t predicted;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predicted = dispatch_result(it);
    pending_results = {pending_results, (use_typed ? typed : predicted)};
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SERVERS_IN_USE) active_servers = value[3:0];
    else done_limit = value;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  // Random traffic: arrivals at a moving time and completions, mostly on busy servers.
  task automatic random_phase(int count, int arrival_pct);
    in_item_t it;
    int       busy_list[$];
    int       k;
    repeat (count) begin
      it = '0;
      clock_now += $urandom_range(0, 1200);
      if ($urandom_range(0, 19) == 0) clock_now = $urandom;
      it.time_now = clock_now;
      it.job_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 10));
      it.server_index = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < arrival_pct) begin
        it.cmd = CMD_ARRIVAL;
      end else begin
        it.cmd = CMD_COMPLETE;
        busy_list.delete();
        for (k = 0; k < NUM_SERVERS; k++) if (srv_busy[k]) busy_list = {busy_list, k};
        if (busy_list.size() > 0 && $urandom_range(0, 9) < 8)
          it.server_index = 3'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{'{CMD_COMPLETE, 32'd0, 4'd0, 3'd0}, 1'b1,
      '{3'd0, 1'b0, 32'd0, 16'd0, 16'd0, 16'd0, ST_IDLE_DONE}},
    '{'{CMD_ARRIVAL, 32'd100, 4'd1, 3'd7}, 1'b1,
      '{3'd0, 1'b1, 32'd356, 16'd0, 16'd1, 16'd1, ST_OK}},
    '{'{CMD_ARRIVAL, 32'd100, 4'd15, 3'd0}, 1'b1,
      '{3'd1, 1'b1, 32'd3940, 16'd0, 16'd1, 16'd15, ST_OK}},
    '{'{CMD_ARRIVAL, 32'hFFFFFFFF, 4'd15, 3'd0}, 1'b0, '0},
    '{'{CMD_ARRIVAL, 32'hFFFFFFFF, 4'd0, 3'd0}, 1'b0, '0},
    '{'{CMD_ARRIVAL, 32'h00000050, 4'd10, 3'd5}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'hFFFFFF00, 4'd0, 3'd0}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'hFFFFFF00, 4'd0, 3'd1}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'h12345678, 4'd3, 3'd7}, 1'b1,
      '{3'd7, 1'b0, 32'd0, 16'd2, 16'd0, 16'd0, ST_IDLE_DONE}},
    '{'{CMD_ARRIVAL, 32'h00000000, 4'd0, 3'd0}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'hAAAAAAAA, 4'd0, 3'd2}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'h55555555, 4'd0, 3'd0}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'h55555555, 4'd0, 3'd1}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'h55555600, 4'd0, 3'd0}, 1'b0, '0},
    '{'{CMD_COMPLETE, 32'h55555700, 4'd0, 3'd2}, 1'b0, '0}
  };

  // Result side: random hold-off per transaction and comparison in order.
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction: %p", out_data);
        end else begin
          want = pending_results.pop_front();
          bad = "";
          if (out_data.server !== want.server) bad = {bad, " server"};
          if (out_data.started !== want.started) bad = {bad, " started"};
          if (out_data.finish_time !== want.finish_time) bad = {bad, " finish_time"};
          if (out_data.served_total !== want.served_total) bad = {bad, " served_total"};
          if (out_data.server_started_count !== want.server_started_count)
            bad = {bad, " server_started_count"};
          if (out_data.server_busy_time !== want.server_busy_time)
            bad = {bad, " server_busy_time"};
          if (out_data.status !== want.status) bad = {bad, " status"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch in%s: expected %p, got %p", bad, want, out_data);
          end
        end
        out_hold = draw_gap(out_burst);
      end
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  // Stimulus and end of run.
  initial begin
    int i, s;
    mismatches = 0;
    in_burst = 0;
    out_burst = 0;
    clock_now = 32'd1000;
    for (s = 0; s < NUM_SERVERS; s++) begin
      fifo_head[s] = 0; fifo_fill[s] = 0; fifo_work[s] = 0; srv_busy[s] = 1'b0;
      srv_free_at[s] = '0; srv_jobs[s] = 0; srv_work[s] = 0;
    end
    done_total = 0;
    active_servers = 4'd3;
    done_limit = 16'd10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < directed.size(); i++)
      send_item(directed[i].it, directed[i].typed, directed[i].want);
    random_phase(60, 50);
    drain();

    write_reg(CFG_SERVERS_IN_USE, 16'd8);
    write_reg(CFG_SERVED_LIMIT, 16'hFFFF);
    random_phase(425, 55);
    drain();
    write_reg(CFG_SERVERS_IN_USE, 16'd0);
    random_phase(250, 60);
    drain();
    write_reg(CFG_SERVERS_IN_USE, 16'd15);
    random_phase(300, 55);
    drain();
    // A single server fed faster than it drains fills its queue.
    write_reg(CFG_SERVERS_IN_USE, 16'd1);
    random_phase(250, 80);
    drain();
    write_reg(CFG_SERVERS_IN_USE, 16'd5);
    write_reg(CFG_SERVED_LIMIT, 16'd0);
    random_phase(150, 60);
    drain();
    write_reg(CFG_SERVERS_IN_USE, 16'd2);
    write_reg(CFG_SERVED_LIMIT, 16'd1);
    random_phase(150, 50);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #(12 * 2000000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
